@@ sv/gtfj_pkg.sv @@
// ----------------------------------------------------------------------------
// gtfj_pkg
// Types, codes and constants shared by the ground test fault judge files.
// ----------------------------------------------------------------------------
`default_nettype none

package gtfj_pkg;

    typedef logic [1:0]  stage_t;
    typedef logic [2:0]  fault_t;
    typedef logic [15:0] word_t;
    typedef logic [3:0]  reg_idx_t;
    typedef logic [7:0]  err_cnt_t;
    typedef logic [16:0] top_t;

    // fault codes
    localparam fault_t FAULT_NONE  = 3'd0;
    localparam fault_t FAULT_HIGH  = 3'd1;
    localparam fault_t FAULT_LOW   = 3'd2;
    localparam fault_t FAULT_VOLT  = 3'd3;
    localparam fault_t FAULT_SHORT = 3'd4;

    // test stages
    localparam stage_t STG_OTHER  = 2'd0;
    localparam stage_t STG_RISE   = 2'd1;
    localparam stage_t STG_CHANGE = 2'd2;
    localparam stage_t STG_TEST   = 2'd3;

    // register indexes
    localparam reg_idx_t REG_UPPER_LIMIT = 4'd0;
    localparam reg_idx_t REG_LOWER_LIMIT = 4'd1;
    localparam reg_idx_t REG_SET_LEVEL   = 4'd2;
    localparam reg_idx_t REG_TEST_TIME   = 4'd3;

    // window top = set_level * 11 / 10 + 10, via reciprocal multiply
    localparam logic [23:0] TOP_RECIP  = 24'd9227469;
    localparam int          TOP_SHIFT  = 23;
    localparam top_t        TOP_OFFSET = 17'd10;

    // sample time thresholds
    localparam word_t CHECK_START = 16'd2;
    localparam word_t SHORT_START = 16'd5;

    // counter thresholds
    localparam err_cnt_t VOLT_CNT_OVER = 8'd2;
    localparam err_cnt_t LOW_CNT_MIN   = 8'd2;
    localparam err_cnt_t CNT_MAX       = 8'hFF;

endpackage

`default_nettype wire

@@ sv/gtfj_if.sv @@
// ----------------------------------------------------------------------------
// gtfj_if
// Valid/ready channels for samples, verdicts and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtfj_sample_if import gtfj_pkg::*; ();
    logic   valid;
    logic   ready;
    stage_t stage;
    word_t  elapsed;
    word_t  voltage;
    word_t  current;

    modport source (output valid, stage, elapsed, voltage, current, input ready);
    modport sink   (input valid, stage, elapsed, voltage, current, output ready);
endinterface

interface gtfj_verdict_if import gtfj_pkg::*; ();
    logic   valid;
    logic   ready;
    fault_t fault;
    logic   end_low;

    modport source (output valid, fault, end_low, input ready);
    modport sink   (input valid, fault, end_low, output ready);
endinterface

interface gtfj_cfg_if import gtfj_pkg::*; ();
    logic     valid;
    logic     ready;
    reg_idx_t index;
    word_t    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/ground_test_fault_judge.sv @@
// ----------------------------------------------------------------------------
// ground_test_fault_judge
// Per-sample fault verdict for a ground-resistance test.
// ----------------------------------------------------------------------------
// Each accepted sample beat (stage, elapsed, voltage, current) yields exactly
// one verdict beat (fault code, latched end_low flag), in order. A sample is
// captured in an input register, judged by one level of compare logic against
// the limits and the two saturating error counters, and the verdict lands in
// an output register, and one sample per cycle is sustained, limited only
// by the verdict side taking its beats. The voltage window top
// (set_level * 11 / 10 + 10) is computed by one reciprocal multiply when
// set_level is written and kept in a register. Register writes are always
// accepted and are meant for idle times.
// ----------------------------------------------------------------------------
`default_nettype none

module ground_test_fault_judge
    import gtfj_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    gtfj_cfg_if.sink        cfg,
    gtfj_sample_if.sink     sample,
    gtfj_verdict_if.source  verdict
);

    // configuration registers
    word_t upper_limit_reg;
    word_t lower_limit_reg;
    word_t set_level_reg;
    word_t test_time_reg;
    top_t  window_top_reg;

    logic [39:0] top_prod;
    top_t        top_next;

    // input stage
    logic   in_valid_reg;
    stage_t stage_reg;
    word_t  elapsed_reg;
    word_t  voltage_reg;
    word_t  current_reg;

    // judge state
    err_cnt_t volt_cnt_reg, volt_cnt_next;
    err_cnt_t low_cnt_reg,  low_cnt_next;
    logic     end_low_reg,  end_low_next;

    // output stage
    logic   out_valid_reg;
    fault_t fault_reg;
    fault_t fault_next;
    logic   out_end_low_reg;

    logic advance;
    logic step;

    // judge terms
    logic     high_hit;
    logic     over_top;
    logic     under_bottom;
    logic     low_cur;
    logic     expired;
    logic     short_window;
    err_cnt_t volt_inc;
    err_cnt_t low_inc;

    assign cfg.ready = 1'b1;

    // window top, reciprocal of 10 folded with the factor 11
    assign top_prod = {24'd0, cfg.data} * {16'd0, TOP_RECIP};
    assign top_next = top_t'(top_prod >> TOP_SHIFT) + TOP_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_limit_reg <= 16'hFFFF;
            lower_limit_reg <= '0;
            set_level_reg   <= '0;
            test_time_reg   <= '0;
            window_top_reg  <= TOP_OFFSET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_UPPER_LIMIT: upper_limit_reg <= cfg.data;
                REG_LOWER_LIMIT: lower_limit_reg <= cfg.data;
                REG_SET_LEVEL:
                begin
                    set_level_reg  <= cfg.data;
                    window_top_reg <= top_next;
                end
                REG_TEST_TIME:   test_time_reg   <= cfg.data;
                default:         ;
            endcase
        end
    end

    // pipeline flow: judge the held sample when the verdict slot frees up
    assign advance      = !out_valid_reg || verdict.ready;
    assign step         = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            stage_reg   <= sample.stage;
            elapsed_reg <= sample.elapsed;
            voltage_reg <= sample.voltage;
            current_reg <= sample.current;
        end
    end

    // shared compare terms
    assign high_hit     = current_reg > upper_limit_reg;
    assign over_top     = {1'b0, voltage_reg} > window_top_reg;
    assign under_bottom = voltage_reg < {1'b0, set_level_reg[15:1]};
    assign low_cur      = current_reg < lower_limit_reg;
    // elapsed + 1 >= test_time, no wrap
    assign expired      = (test_time_reg != '0) &&
                          ({1'b0, elapsed_reg} + 17'd1 >= {1'b0, test_time_reg});
    assign short_window = (elapsed_reg >= SHORT_START) || (elapsed_reg == test_time_reg);
    assign volt_inc     = (volt_cnt_reg == CNT_MAX) ? CNT_MAX : volt_cnt_reg + 8'd1;
    assign low_inc      = (low_cnt_reg == CNT_MAX) ? CNT_MAX : low_cnt_reg + 8'd1;

    always_comb
    begin
        fault_next    = FAULT_NONE;
        volt_cnt_next = volt_cnt_reg;
        low_cnt_next  = low_cnt_reg;
        end_low_next  = end_low_reg;

        if (high_hit)
        begin
            fault_next = FAULT_HIGH;
        end
        else if (stage_reg == STG_RISE || stage_reg == STG_CHANGE)
        begin
            // over-voltage while ramping needs more than two hits in a row
            if (over_top)
            begin
                volt_cnt_next = volt_inc;
                if (volt_inc > VOLT_CNT_OVER)
                begin
                    fault_next = FAULT_VOLT;
                end
            end
            else
            begin
                volt_cnt_next = '0;
            end
        end
        else if (stage_reg == STG_TEST && elapsed_reg > CHECK_START)
        begin
            if (short_window && voltage_reg == '0)
            begin
                fault_next = FAULT_SHORT;
            end
            else if (!expired && (under_bottom || over_top))
            begin
                fault_next = FAULT_VOLT;
            end

            if (fault_next == FAULT_NONE)
            begin
                if (low_cur)
                begin
                    low_cnt_next = low_inc;
                    if (low_inc >= LOW_CNT_MIN)
                    begin
                        fault_next = FAULT_LOW;
                    end
                end
                else
                begin
                    low_cnt_next = '0;
                end
            end

            // end-of-test verdict latched on a clean final sample
            if (fault_next == FAULT_NONE && expired)
            begin
                end_low_next = low_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_cnt_reg  <= '0;
            low_cnt_reg   <= '0;
            end_low_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                volt_cnt_reg <= volt_cnt_next;
                low_cnt_reg  <= low_cnt_next;
                end_low_reg  <= end_low_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            fault_reg       <= fault_next;
            out_end_low_reg <= end_low_next;
        end
    end

    assign verdict.valid   = out_valid_reg;
    assign verdict.fault   = fault_reg;
    assign verdict.end_low = out_end_low_reg;

    // judge state only moves when a sample is judged
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(volt_cnt_reg) && $stable(low_cnt_reg) && $stable(end_low_reg))
        else $error("judge state changed without a judged sample");

    // a pending verdict matches the live latched flag
    a_end_low_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_end_low_reg == end_low_reg))
        else $error("verdict end_low differs from latched flag");

    // low fault only with at least two low hits counted
    a_low_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fault_reg == FAULT_LOW) |-> (low_cnt_reg >= LOW_CNT_MIN))
        else $error("low fault with too few low hits");

    // low counter only steps by one, holds at max, or clears
    a_low_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (low_cnt_reg == '0) || (low_cnt_reg == $past(low_cnt_reg)) ||
                 (low_cnt_reg == $past(low_cnt_reg) + 8'd1))
        else $error("low counter jumped");

endmodule

`default_nettype wire

@@ test/ground_test_fault_judge_tb.sv @@
// ----------------------------------------------------------------------------
// ground_test_fault_judge_tb
// Self-checking bench for the ground test fault judge: directed samples for
// each fault rule, long runs that saturate both error counters, then random
// test sessions under several limit settings with bursty stalls on both the
// sample and the verdict side. Every verdict beat is compared with an
// in-order prediction that is made when its sample beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ground_test_fault_judge_tb;

    import gtfj_pkg::*;

    // voltage window arithmetic: top = level * 11 / 10 + 10, bottom = level / 2
    localparam logic [31:0] WIN_NUM    = 32'd11;
    localparam logic [31:0] WIN_DEN    = 32'd10;
    localparam logic [31:0] WIN_OFFSET = 32'd10;
    localparam logic [31:0] WIN_LO_DIV = 32'd2;

    localparam int WORD_MAX      = 65535;
    localparam int REG_IDX_MAX   = 15;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_TAIL    = 4;        // input and output register plus margin
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_MAX    = 10;
    localparam int SESSION_COUNT = 7;
    localparam int SESSION_BEATS = 130;
    localparam int SAT_RUN       = 300;      // longer than the counters can count

    typedef struct packed {
        fault_t fault;
        logic   end_low;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    gtfj_cfg_if     cfg_bus ();
    gtfj_sample_if  sample_bus ();
    gtfj_verdict_if verdict_bus ();

    ground_test_fault_judge dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .sample  (sample_bus),
        .verdict (verdict_bus)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // shadow copy of the limit registers and of the judge state
    // ------------------------------------------------------------------------
    word_t    lim_upper  = '1;
    word_t    lim_lower  = '0;
    word_t    set_lvl    = '0;
    word_t    test_dur   = '0;
    err_cnt_t volt_cnt   = '0;
    err_cnt_t low_cnt    = '0;
    logic     end_low_q  = 1'b0;

    verdict_t pending_verdicts [$];

    int  error_count  = 0;
    int  cycle_count  = 0;
    int  samples_sent = 0;
    bit  no_idle      = 1'b0;

    // ------------------------------------------------------------------------
    // verdict prediction for one accepted sample; updates the shadow state
    // ------------------------------------------------------------------------
    function automatic verdict_t judge_sample(stage_t st, word_t el, word_t volt, word_t cur);
        logic [31:0] win_top;
        logic [31:0] win_bot;
        logic        at_end;
        verdict_t    v;
        win_top = ({16'd0, set_lvl} * WIN_NUM) / WIN_DEN + WIN_OFFSET;
        win_bot = {16'd0, set_lvl} / WIN_LO_DIV;
        // the test counts as expired from the last time unit on
        at_end  = (test_dur != '0) && ({16'd0, el} + 32'd1 >= {16'd0, test_dur});
        v.fault = FAULT_NONE;

        if (cur > lim_upper)
        begin
            // high current wins in every stage and leaves the state alone
            v.fault = FAULT_HIGH;
        end
        else if (st == STG_RISE || st == STG_CHANGE)
        begin
            if ({16'd0, volt} > win_top)
            begin
                if (volt_cnt != CNT_MAX)
                    volt_cnt = volt_cnt + 1'b1;
                if (volt_cnt > VOLT_CNT_OVER)
                    v.fault = FAULT_VOLT;
            end
            else
            begin
                volt_cnt = '0;
            end
        end
        else if (st == STG_TEST && el > CHECK_START)
        begin
            if ((el >= SHORT_START || el == test_dur) && volt == '0)
                v.fault = FAULT_SHORT;
            else if (!at_end && ({16'd0, volt} < win_bot || {16'd0, volt} > win_top))
                v.fault = FAULT_VOLT;

            if (v.fault == FAULT_NONE)
            begin
                if (cur < lim_lower)
                begin
                    if (low_cnt != CNT_MAX)
                        low_cnt = low_cnt + 1'b1;
                    if (low_cnt >= LOW_CNT_MIN)
                        v.fault = FAULT_LOW;
                end
                else
                begin
                    low_cnt = '0;
                end
            end

            // end-of-test verdict latches only on a clean sample
            if (v.fault == FAULT_NONE && at_end)
                end_low_q = (cur < lim_lower);
        end

        v.end_low = end_low_q;
        return v;
    endfunction

    function automatic void flag_error(string what, verdict_t want, fault_t got_fault,
                                       logic got_end);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t %s: expected fault %0d end_low %0b, got fault %0d end_low %0b",
                     $realtime, what, want.fault, want.end_low, got_fault, got_end);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one sample beat; optional random gap first, valid stays high afterwards
    task automatic send_sample(stage_t st, word_t el, word_t volt, word_t cur);
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid   <= 1'b1;
        sample_bus.stage   <= st;
        sample_bus.elapsed <= el;
        sample_bus.voltage <= volt;
        sample_bus.current <= cur;
        do @(posedge clk); while (!sample_bus.ready);
        pending_verdicts.push_back(judge_sample(st, el, volt, cur));
        samples_sent++;
    endtask

    // stop sending and let every outstanding verdict come back
    task automatic wait_idle();
        sample_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // one register write beat; valid stays high for a following write
    task automatic write_reg(reg_idx_t idx, word_t value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            REG_UPPER_LIMIT: lim_upper = value;
            REG_LOWER_LIMIT: lim_lower = value;
            REG_SET_LEVEL:   set_lvl   = value;
            REG_TEST_TIME:   test_dur  = value;
            default: ;
        endcase
    endtask

    // reprogram all limits while the judge is idle
    task automatic set_limits(word_t upper, word_t lower, word_t level, word_t dur,
                              bit poke_unused);
        wait_idle();
        write_reg(REG_UPPER_LIMIT, upper);
        write_reg(REG_LOWER_LIMIT, lower);
        write_reg(REG_SET_LEVEL, level);
        write_reg(REG_TEST_TIME, dur);
        // an index past the register map must be ignored
        if (poke_unused)
            write_reg(reg_idx_t'($urandom_range(REG_TEST_TIME + 1, REG_IDX_MAX)),
                      word_t'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic word_t pick_near(int center, int spread);
        int x;
        x = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (x < 0)
            x = 0;
        if (x > WORD_MAX)
            x = WORD_MAX;
        return word_t'(x);
    endfunction

    function automatic int window_top_int();
        return int'(set_lvl) * int'(WIN_NUM) / int'(WIN_DEN) + int'(WIN_OFFSET);
    endfunction

    // current mostly between the limits, with boundary and out-of-range hits
    function automatic word_t pick_current();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return pick_near(lim_upper, 2);
        else if (sel <= 2)
            return pick_near(lim_lower, 2);
        else if (sel == 3)
            return word_t'($urandom_range(0, lim_lower));
        else if (lim_lower <= lim_upper)
            return word_t'($urandom_range(lim_lower, lim_upper));
        return word_t'($urandom);
    endfunction

    // voltage mostly inside the window, sometimes shorted or on an edge
    function automatic word_t pick_test_voltage();
        int sel;
        int top_v;
        int bot_v;
        sel   = $urandom_range(0, 9);
        top_v = window_top_int();
        bot_v = int'(set_lvl) / int'(WIN_LO_DIV);
        if (top_v > WORD_MAX)
            top_v = WORD_MAX;
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return pick_near(bot_v, 3);
        else if (sel == 2)
            return pick_near(top_v, 3);
        return word_t'($urandom_range(bot_v, top_v));
    endfunction

    // rise, change, then a test stage with elapsed counting up
    task automatic run_test_sequence();
        int n;
        int len;
        int base;
        int el;
        n = $urandom_range(0, 5);
        repeat (n)
            send_sample(STG_RISE, word_t'($urandom_range(0, 3)),
                        pick_near(window_top_int(), 3), pick_current());
        n = $urandom_range(0, 5);
        repeat (n)
            send_sample(STG_CHANGE, word_t'($urandom_range(0, 3)),
                        pick_near(window_top_int(), 3), pick_current());

        if (test_dur != '0 && test_dur < 40)
            len = int'(test_dur) + $urandom_range(0, 3);
        else
            len = $urandom_range(3, 30);
        base = 0;
        // with a long test time jump near its end so expiry gets exercised
        if (test_dur >= 40 && $urandom_range(0, 1) == 1)
            base = int'(test_dur) - 20;
        for (el = base; el < base + len; el++)
            send_sample(STG_TEST, word_t'(el), pick_test_voltage(), pick_current());

        if ($urandom_range(0, 1) == 1)
            send_sample(STG_OTHER, word_t'($urandom), word_t'($urandom), pick_current());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // limits straight out of reset
    task automatic test_reset_defaults();
        send_sample(STG_OTHER, '0, '0, '0);
        send_sample(STG_RISE, '0, '1, '1);
        send_sample(STG_TEST, '1, '0, '0);
    endtask

    // current above the upper limit in rise and test stages, and exactly on it
    task automatic test_high_current();
        set_limits(16'd1000, 16'd0, 16'd100, 16'd0, 1'b0);
        send_sample(STG_RISE, 16'd0, 16'd500, 16'd1001);
        send_sample(STG_TEST, 16'd6, 16'd0, 16'hFFFF);
        send_sample(STG_OTHER, 16'd0, 16'd100, 16'd1000);
    endtask

    // over-voltage count across rise and change, cleared by a good sample
    task automatic test_overvoltage_ramp();
        repeat (3)
            send_sample(STG_RISE, 16'd0, 16'd121, 16'd10);
        send_sample(STG_CHANGE, 16'd1, 16'd121, 16'd10);
        send_sample(STG_RISE, 16'd1, 16'd120, 16'd10);
        send_sample(STG_CHANGE, 16'd1, 16'd121, 16'd10);
    endtask

    // start delay, window, short, low count and end-of-test latch
    task automatic test_stage_window();
        set_limits(16'd60000, 16'd200, 16'd100, 16'd10, 1'b0);
        send_sample(STG_TEST, 16'd2, 16'd0, 16'd0);
        send_sample(STG_TEST, 16'd3, 16'd0, 16'd300);
        send_sample(STG_TEST, 16'd5, 16'd0, 16'd300);
        send_sample(STG_TEST, 16'd6, 16'd100, 16'd100);
        send_sample(STG_TEST, 16'd7, 16'd100, 16'd100);
        send_sample(STG_TEST, 16'd8, 16'd100, 16'd300);
        // window not checked at expiry, low current latches the end flag
        send_sample(STG_TEST, 16'd9, 16'd30, 16'd100);
        send_sample(STG_TEST, 16'd9, 16'd30, 16'd300);
    endtask

    // short when elapsed equals a test time below the short start
    task automatic test_short_at_test_time();
        set_limits(16'd60000, 16'd200, 16'd100, 16'd4, 1'b0);
        send_sample(STG_TEST, 16'd4, 16'd0, 16'd300);
        send_sample(STG_TEST, 16'd3, 16'd0, 16'd0);
    endtask

    // all registers at their top values, elapsed at the top of its range
    task automatic test_expiry_extremes();
        set_limits('1, '1, '1, '1, 1'b1);
        send_sample(STG_TEST, 16'd65534, '1, 16'd65534);
        send_sample(STG_TEST, '1, '1, 16'd65534);
        send_sample(STG_RISE, '1, '1, '0);
    endtask

    // long runs that drive both counters into saturation
    task automatic test_counter_saturation();
        set_limits('1, 16'd100, 16'd0, 16'd0, 1'b0);
        repeat (SAT_RUN)
            send_sample(stage_t'($urandom_range(STG_RISE, STG_CHANGE)),
                        word_t'($urandom), word_t'($urandom_range(11, WORD_MAX)),
                        word_t'($urandom_range(0, WORD_MAX)));
        // voltage inside the small window, current below the lower limit
        repeat (SAT_RUN)
            send_sample(STG_TEST, word_t'($urandom_range(5, WORD_MAX)),
                        word_t'($urandom_range(1, 10)), word_t'($urandom_range(0, 99)));
    endtask

    // random sessions under changing limits, quiet handshakes in the last one
    task automatic test_random_sessions();
        int s;
        int start;
        int n;
        for (s = 0; s < SESSION_COUNT; s++)
        begin
            if (s == 0)
                set_limits('0, '0, '0, '0, 1'b1);
            else if (s == 1)
                set_limits('1, '1, '1, '1, 1'b1);
            else if (s == 2)
                set_limits(word_t'($urandom), word_t'($urandom), word_t'($urandom),
                           word_t'($urandom), 1'b1);
            else
                set_limits(word_t'($urandom_range(2000, WORD_MAX)),
                           word_t'($urandom_range(0, 2000)),
                           word_t'($urandom_range(0, 3000)),
                           ($urandom_range(0, 3) == 0) ? '0 : word_t'($urandom_range(4, 30)),
                           1'b1);
            if (s == SESSION_COUNT - 1)
                no_idle = 1'b1;
            start = samples_sent;
            while (samples_sent - start < SESSION_BEATS)
            begin
                if ($urandom_range(0, 9) < 7)
                    run_test_sequence();
                else
                begin
                    // noise: any field value, any stage
                    n = $urandom_range(1, 5);
                    repeat (n)
                        send_sample(stage_t'($urandom), word_t'($urandom),
                                    word_t'($urandom), word_t'($urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // verdict side: bursty ready, quiet at the end
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        verdict_bus.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (no_idle)
                verdict_bus.ready <= 1'b1;
            else if (hold > 0)
                hold--;
            else if ($urandom_range(0, 3) == 0)
            begin
                verdict_bus.ready <= 1'b0;
                hold = $urandom_range(1, 18) - 1;
            end
            else
            begin
                verdict_bus.ready <= 1'b1;
                hold = $urandom_range(1, 40) - 1;
            end
        end
    end

    // each verdict beat against the oldest prediction
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && verdict_bus.valid && verdict_bus.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                flag_error("verdict with no sample pending", '0, verdict_bus.fault,
                           verdict_bus.end_low);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (want.fault !== verdict_bus.fault || want.end_low !== verdict_bus.end_low)
                    flag_error("verdict mismatch", want, verdict_bus.fault,
                               verdict_bus.end_low);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        sample_bus.valid   = 1'b0;
        sample_bus.stage   = STG_OTHER;
        sample_bus.elapsed = '0;
        sample_bus.voltage = '0;
        sample_bus.current = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_UPPER_LIMIT;
        cfg_bus.data       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_high_current();
        test_overvoltage_ramp();
        test_stage_window();
        test_short_at_test_time();
        test_expiry_extremes();
        test_counter_saturation();
        test_random_sessions();

        wait_idle();
        while (pending_verdicts.size() != 0)
            flag_error("verdict never arrived", pending_verdicts.pop_front(), '0, 1'b0);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
